// ===== src/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the box filter downscaler
// Fixed-point widths, register map, configuration record and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   localparam int FRAC_BITS     = 22;
   localparam int W_W           = FRAC_BITS + 1;   // weight width
   localparam int ACC_W         = FRAC_BITS + 9;   // accumulator / line-store width
   localparam int MAX_OUT_WIDTH = 2048;
   localparam int MAX_IN_SIZE   = 4096;
   localparam int COL_W         = $clog2(MAX_OUT_WIDTH);
   localparam int ADDR_W        = 5;

   localparam logic [W_W-1:0] NORM = {1'b1, {FRAC_BITS{1'b0}}};

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_CONTRIB_X  = 3'd4;
   localparam logic [2:0] REG_CONTRIB_Y  = 3'd5;

   typedef logic [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [12:0]    in_width;
      logic [12:0]    in_height;
      logic [11:0]    out_width;
      logic [12:0]    out_height;
      logic [W_W-1:0] contrib_x;
      logic [W_W-1:0] contrib_y;
   } cfg_type;

   typedef struct packed {
      logic clear_wr;
      logic latch;
      logic prep;
      logic horz;
      logic close_rd;
      logic close_wr;
      logic split;
      logic in_next;
      logic vert;
      logic drain_rd;
      logic drain_emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_drain;
      logic drain_pending;
      logic split_needed;
      logic active;
      logic close_stall;
      logic eol;
      logic end_close;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/bfd_if.sv =====
// ----------------------------------------------------------------------------
// bfd_if: valid/ready channels of the box filter downscaler
// Input pixel/drain channel and output pixel channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, command, red, green, blue, input ready);
   modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface bfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic [10:0] out_column;
   logic [11:0] out_row;
   logic        frame_done;

   modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                   frame_done, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_column, out_row,
                   frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/box_filter_image_downscaler_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_image_downscaler_unit: area-average RGB image downscaler
// Shrinks a raster-order RGB pixel stream by box filtering with 22-bit
// fraction weights; column sums are kept in an internal line store.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one word per pixel (command 0) or per drain request
//    (command 1); rsp_bus carries finished output pixels with their column,
//    row and a frame_done flag on the last pixel of the frame.
//  - Program sizes and contrib_x/contrib_y through the APB port while idle.
//  - A word is accepted only while the controller is idle, so each pixel
//    or drain word is finished before the next is taken. A pixel that
//    closes a column or ends a row takes more steps than one that stays
//    inside an output column; a drain word with no drain pending skips the read.
//  - A result is loaded into the output register when a column closes,
//    inside the row or at row end, or when a pending drain word is emitted.
//  - A column close reads the line store, then writes it back in a separate
//    step, with a registered multiply ahead of each update.
//  - Results leave through an output register; the next word is accepted
//    while a result still waits. A step that must emit holds in place while
//    the receiver stalls with the output register full.
//  - After reset, a clearing pass zeroes the 2048-entry line store;
//    req_bus.ready stays low until it ends. Config writes are taken
//    throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_image_downscaler_unit import bfd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   bfd_req_if.sink                req_bus,
   bfd_rsp_if.source              rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    ctl_ready;

   // hold the register file
   bfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequence each word through its phases
   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_bus.ready = ctl_ready;

   // accumulate, weight, store and emit
   bfd_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .req_command (req_bus.command),
      .req_red     (req_bus.red),
      .req_green   (req_bus.green),
      .req_blue    (req_bus.blue),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== src/bfd_csr.sv =====
// ----------------------------------------------------------------------------
// bfd_csr: configuration registers
// APB-style write/read of the six size and weight registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_csr import bfd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;

   assign idx    = paddr[ADDR_W-1:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            REG_IN_WIDTH:   cfg_in.in_width   = pwdata[12:0];
            REG_IN_HEIGHT:  cfg_in.in_height  = pwdata[12:0];
            REG_OUT_WIDTH:  cfg_in.out_width  = pwdata[11:0];
            REG_OUT_HEIGHT: cfg_in.out_height = pwdata[12:0];
            REG_CONTRIB_X:  cfg_in.contrib_x  = pwdata[W_W-1:0];
            REG_CONTRIB_Y:  cfg_in.contrib_y  = pwdata[W_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_IN_WIDTH:   prdata = 32'(cfg_ff.in_width);
         REG_IN_HEIGHT:  prdata = 32'(cfg_ff.in_height);
         REG_OUT_WIDTH:  prdata = 32'(cfg_ff.out_width);
         REG_OUT_HEIGHT: prdata = 32'(cfg_ff.out_height);
         REG_CONTRIB_X:  prdata = 32'(cfg_ff.contrib_x);
         REG_CONTRIB_Y:  prdata = 32'(cfg_ff.contrib_y);
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width   <= 13'd640;
         cfg_ff.in_height  <= 13'd480;
         cfg_ff.out_width  <= 12'd320;
         cfg_ff.out_height <= 13'd240;
         cfg_ff.contrib_x  <= NORM >> 1;
         cfg_ff.contrib_y  <= NORM >> 1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfd_ctrl: sequencing state machine
// Clears the line store, steps words one at a time through prepare, horizontal,
// close and vertical phases or a drain read/emit; issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ctrl import bfd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_PREP  = 4'd2;
   localparam logic [3:0] ST_HORZ  = 4'd3;
   localparam logic [3:0] ST_CRD   = 4'd4;
   localparam logic [3:0] ST_CWR   = 4'd5;
   localparam logic [3:0] ST_SPLIT = 4'd6;
   localparam logic [3:0] ST_ENDS  = 4'd7;
   localparam logic [3:0] ST_VERT  = 4'd8;
   localparam logic [3:0] ST_DEMIT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       ret_ff, ret_in;    // close issued from row end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sts.is_drain) begin
               if (sts.drain_pending) begin
                  cmd.drain_rd = 1'b1;
                  state_in     = ST_DEMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.prep = 1'b1;
               state_in = ST_HORZ;
            end
         end
         ST_HORZ: begin
            cmd.horz = sts.active;
            if (sts.active && sts.split_needed) begin
               ret_in   = 1'b0;
               state_in = ST_CRD;
            end else begin
               state_in = ST_ENDS;
            end
         end
         ST_CRD: begin
            cmd.close_rd = 1'b1;
            state_in     = ST_CWR;
         end
         ST_CWR: begin
            if (!sts.close_stall) begin
               cmd.close_wr = 1'b1;
               state_in     = ret_ff ? ST_VERT : ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_ENDS;
         end
         ST_ENDS: begin
            if (!sts.eol) begin
               cmd.in_next = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.end_close) begin
               ret_in   = 1'b1;
               state_in = ST_CRD;
            end else begin
               state_in = ST_VERT;
            end
         end
         ST_VERT: begin
            cmd.vert = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DEMIT: begin
            if (sts.out_free) begin
               cmd.drain_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bfd_dpath.sv =====
// ----------------------------------------------------------------------------
// bfd_dpath: accumulators, weights, counters and column-sum line store
// Executes one controller command per cycle and holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_dpath import bfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   input  wire logic       req_command,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   bfd_rsp_if.source       rsp_bus
);

   localparam int MEM_W = 3 * ACC_W;

   logic [MEM_W-1:0] mem [MAX_OUT_WIDTH];

   logic             drain_ff;
   logic [7:0]       pix_ff [3];
   acc_type          acc_ff [3], acc_in [3];
   acc_type          pn_ff [3], pn_in [3];
   acc_type          pr_ff [3], pr_in [3];
   logic [MEM_W-1:0] rd_ff;
   logic [W_W-1:0]   wlx_ff, wlx_in, wly_ff, wly_in;
   logic [W_W-1:0]   rwn_ff, rwn_in, rwr_ff, rwr_in;
   logic             rco_ff, rco_in;
   logic [11:0]      in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [11:0]      out_col_ff, out_col_in, drain_col_ff, drain_col_in;
   logic [12:0]      out_row_ff, out_row_in;
   logic             frame_over_ff, frame_over_in, drain_pending_ff, drain_pending_in;
   logic             row_full_ff, row_full_in, last_emitted_ff, last_emitted_in;
   logic [COL_W-1:0] clr_addr_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_color_ff [3], rsp_color_in [3];
   logic [10:0]      rsp_col_ff, rsp_col_in;
   logic [11:0]      rsp_row_ff, rsp_row_in;
   logic             rsp_done_ff, rsp_done_in;

   logic [11:0]      ow;
   logic [12:0]      oh, iw, ih;
   logic [COL_W-1:0] col_c, col_d;
   logic             out_free, last_out_row, eol, last_row;
   logic [W_W-1:0]   hw, sw, rest;
   acc_type          mixed [3];
   logic [MEM_W-1:0] mem_wd;
   logic [COL_W-1:0] mem_wa, mem_ra;
   logic             mem_we, mem_re, frame_over_nx;

   // effective sizes: zero counts as one, large values saturate except out_height
   assign ow = (cfg.out_width == 12'd0) ? 12'd1 :
               (cfg.out_width > 12'(MAX_OUT_WIDTH)) ? 12'(MAX_OUT_WIDTH) : cfg.out_width;
   assign oh = (cfg.out_height == 13'd0) ? 13'd1 : cfg.out_height;
   assign iw = (cfg.in_width == 13'd0) ? 13'd1 :
               (cfg.in_width > 13'(MAX_IN_SIZE)) ? 13'(MAX_IN_SIZE) : cfg.in_width;
   assign ih = (cfg.in_height == 13'd0) ? 13'd1 :
               (cfg.in_height > 13'(MAX_IN_SIZE)) ? 13'(MAX_IN_SIZE) : cfg.in_height;

   assign col_c = out_col_ff[COL_W] ? '1 : out_col_ff[COL_W-1:0];
   assign col_d = drain_col_ff[COL_W] ? '1 : drain_col_ff[COL_W-1:0];

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign last_out_row = (14'(out_row_ff) + 14'd1) >= {1'b0, oh};
   assign eol          = (13'(in_col_ff) + 13'd1) >= iw;
   assign last_row     = (13'(in_row_ff) + 13'd1) >= ih;
   assign hw           = (wlx_ff <= cfg.contrib_x) ? wlx_ff : cfg.contrib_x;
   assign sw           = cfg.contrib_x - wlx_ff;
   assign rest         = cfg.contrib_y - wly_ff;
   assign frame_over_nx = frame_over_ff || (rco_ff && last_out_row);

   assign sts.clear_last    = (clr_addr_ff == '1);
   assign sts.is_drain      = drain_ff;
   assign sts.drain_pending = drain_pending_ff;
   assign sts.split_needed  = (wlx_ff <= cfg.contrib_x);
   assign sts.active        = !frame_over_ff && !row_full_ff;
   assign sts.close_stall   = rco_ff && !out_free;
   assign sts.eol           = eol;
   assign sts.end_close     = !frame_over_ff && !last_emitted_ff && !row_full_ff;
   assign sts.out_free      = out_free;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mixed[k] = (in_row_ff == 12'd0) ? pn_ff[k]
                                         : rd_ff[k*ACC_W +: ACC_W] + pn_ff[k];
      end
   end

   // line store ports
   always_comb begin
      mem_we = cmd.clear_wr || cmd.close_wr;
      mem_wa = cmd.clear_wr ? clr_addr_ff : col_c;
      mem_wd = '0;
      if (cmd.close_wr) begin
         for (int k = 0; k < 3; k++) begin
            mem_wd[k*ACC_W +: ACC_W] = rco_ff ? pr_ff[k] : mixed[k];
         end
      end
      mem_re = cmd.close_rd || cmd.drain_rd;
      mem_ra = cmd.drain_rd ? col_d : col_c;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_comb begin
      acc_in           = acc_ff;
      pn_in            = pn_ff;
      pr_in            = pr_ff;
      wlx_in           = wlx_ff;
      wly_in           = wly_ff;
      rwn_in           = rwn_ff;
      rwr_in           = rwr_ff;
      rco_in           = rco_ff;
      in_col_in        = in_col_ff;
      in_row_in        = in_row_ff;
      out_col_in       = out_col_ff;
      out_row_in       = out_row_ff;
      drain_col_in     = drain_col_ff;
      frame_over_in    = frame_over_ff;
      drain_pending_in = drain_pending_ff;
      row_full_in      = row_full_ff;
      last_emitted_in  = last_emitted_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_color_in     = rsp_color_ff;
      rsp_col_in       = rsp_col_ff;
      rsp_row_in       = rsp_row_ff;
      rsp_done_in      = rsp_done_ff;

      if (cmd.prep) begin
         drain_pending_in = 1'b0;
         if (in_col_ff == 12'd0 && in_row_ff == 12'd0) begin
            wly_in        = NORM - cfg.contrib_y;
            rwn_in        = cfg.contrib_y;
            rwr_in        = '0;
            rco_in        = 1'b0;
            out_row_in    = '0;
            frame_over_in = 1'b0;
         end
         if (in_col_ff == 12'd0) begin
            for (int k = 0; k < 3; k++) acc_in[k] = '0;
            wlx_in          = NORM;
            out_col_in      = '0;
            row_full_in     = 1'b0;
            last_emitted_in = 1'b0;
         end
      end

      // add the pixel's share of the current column
      if (cmd.horz) begin
         for (int k = 0; k < 3; k++) begin
            acc_in[k] = acc_ff[k] + ACC_W'(ACC_W'(pix_ff[k]) * ACC_W'(hw));
         end
         if (wlx_ff > cfg.contrib_x) begin
            wlx_in          = wlx_ff - cfg.contrib_x;
            last_emitted_in = 1'b0;
         end
      end

      // vertical weighting of the finished horizontal sum
      if (cmd.close_rd) begin
         for (int k = 0; k < 3; k++) begin
            pn_in[k] = ACC_W'(ACC_W'(acc_ff[k][ACC_W-1:FRAC_BITS]) * ACC_W'(rwn_ff));
            pr_in[k] = ACC_W'(ACC_W'(acc_ff[k][ACC_W-1:FRAC_BITS]) * ACC_W'(rwr_ff));
         end
      end

      if (cmd.close_wr && rco_ff) begin
         rsp_valid_in = 1'b1;
         for (int k = 0; k < 3; k++) rsp_color_in[k] = mixed[k][FRAC_BITS +: 8];
         rsp_col_in  = col_c;
         rsp_row_in  = out_row_ff[11:0];
         rsp_done_in = last_out_row && ((12'(col_c) + 12'd1) >= ow);
      end

      // carry the straddling pixel's leftover into the next column
      if (cmd.split) begin
         for (int k = 0; k < 3; k++) acc_in[k] = ACC_W'(ACC_W'(pix_ff[k]) * ACC_W'(sw));
         wlx_in          = NORM - sw;
         last_emitted_in = 1'b1;
         out_col_in      = out_col_ff + 12'd1;
         if ((13'(out_col_ff) + 13'd1) >= 13'(ow)) row_full_in = 1'b1;
      end

      if (cmd.in_next) in_col_in = in_col_ff + 12'd1;

      if (cmd.vert) begin
         if (!frame_over_ff) begin
            if (rco_ff && !last_out_row) out_row_in = out_row_ff + 13'd1;
            frame_over_in = frame_over_nx;
            if (!frame_over_nx) begin
               rco_in = 1'b0;
               if (wly_ff > cfg.contrib_y) begin
                  rwn_in = cfg.contrib_y;
                  wly_in = wly_ff - cfg.contrib_y;
               end else begin
                  rwn_in = wly_ff;
                  rwr_in = rest;
                  wly_in = NORM - rest;
                  rco_in = 1'b1;
               end
            end
         end
         in_col_in = '0;
         if (last_row) begin
            in_row_in = '0;
            if (!frame_over_nx) begin
               drain_pending_in = 1'b1;
               drain_col_in     = '0;
            end
         end else begin
            in_row_in = in_row_ff + 12'd1;
         end
      end

      if (cmd.drain_emit) begin
         rsp_valid_in = 1'b1;
         for (int k = 0; k < 3; k++) rsp_color_in[k] = rd_ff[k*ACC_W + FRAC_BITS +: 8];
         rsp_col_in   = col_d;
         rsp_row_in   = out_row_ff[11:0];
         rsp_done_in  = (12'(col_d) + 12'd1) >= ow;
         drain_col_in = drain_col_ff + 12'd1;
         if ((12'(col_d) + 12'd1) >= ow) drain_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         drain_ff  <= req_command;
         pix_ff[0] <= req_red;
         pix_ff[1] <= req_green;
         pix_ff[2] <= req_blue;
      end
      pn_ff        <= pn_in;
      pr_ff        <= pr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
         wlx_ff           <= NORM;
         wly_ff           <= NORM >> 1;
         rwn_ff           <= NORM >> 1;
         rwr_ff           <= '0;
         rco_ff           <= 1'b0;
         in_col_ff        <= '0;
         in_row_ff        <= '0;
         out_col_ff       <= '0;
         out_row_ff       <= '0;
         drain_col_ff     <= '0;
         frame_over_ff    <= 1'b0;
         drain_pending_ff <= 1'b0;
         row_full_ff      <= 1'b0;
         last_emitted_ff  <= 1'b0;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         acc_ff           <= acc_in;
         wlx_ff           <= wlx_in;
         wly_ff           <= wly_in;
         rwn_ff           <= rwn_in;
         rwr_ff           <= rwr_in;
         rco_ff           <= rco_in;
         in_col_ff        <= in_col_in;
         in_row_ff        <= in_row_in;
         out_col_ff       <= out_col_in;
         out_row_ff       <= out_row_in;
         drain_col_ff     <= drain_col_in;
         frame_over_ff    <= frame_over_in;
         drain_pending_ff <= drain_pending_in;
         row_full_ff      <= row_full_in;
         last_emitted_ff  <= last_emitted_in;
         if (cmd.clear_wr) clr_addr_ff <= clr_addr_ff + COL_W'(1);
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_red    = rsp_color_ff[0];
   assign rsp_bus.out_green  = rsp_color_ff[1];
   assign rsp_bus.out_blue   = rsp_color_ff[2];
   assign rsp_bus.out_column = rsp_col_ff;
   assign rsp_bus.out_row    = rsp_row_ff;
   assign rsp_bus.frame_done = rsp_done_ff;

endmodule

`default_nettype wire
